>>> sv/tes_pkg.sv
// tes_pkg: shared constants, types and codes for the timer event scheduler.
// No dependencies; imported by tes_slot_ram, timer_event_scheduler and tes_checker.
`timescale 1ns / 1ps

package tes_pkg;

  localparam int NUM_TIMERS  = 16;
  localparam int TIME_BITS   = 32;
  localparam int ID_BITS     = $clog2(NUM_TIMERS);
  localparam int CNT_BITS    = $clog2(NUM_TIMERS + 1);
  localparam int PORT_ID_W   = 4;
  localparam int PORT_TIME_W = 32;
  localparam int KIND_W      = 2;

  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [ID_BITS-1:0]   slot_idx_t;

  typedef struct packed {
    time_t deadline;
    time_t period;
  } slot_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SNAP,
    S_FIND,
    S_RD,
    S_FIRE,
    S_RELOAD
  } state_e;

endpackage

>>> sv/tes_slot_ram.sv
// tes_slot_ram: deadline/period storage for all timer slots.
// One write port, one read port with registered read data. Depends on tes_pkg.
`timescale 1ns / 1ps

module tes_slot_ram import tes_pkg::*; (
  input  logic      clk_i,
  input  logic      we_i,
  input  slot_idx_t waddr_i,
  input  slot_t     wdata_i,
  input  logic      re_i,
  input  slot_idx_t raddr_i,
  output slot_t     rdata_o
);

  slot_t mem [NUM_TIMERS];
  slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/timer_event_scheduler.sv
// timer_event_scheduler: top level, command sequencer around one slot RAM,
// one shared comparator and one shared saturating adder. Depends on tes_pkg, tes_slot_ram.
//
//   channel   | direction | handshake                 | payload
//   ----------+-----------+---------------------------+-------------------------------------
//   command   | in        | start && !busy            | kind, timer_id, period, start_time,
//             |           |                           | current_time
//   fire      | out       | fire_valid_o, 1 cycle     | fired_id_o, due_time_o, last_fire_o
//
// Add and remove complete in the accept cycle; busy stays low.
// A tick first snapshots due timers (one RAM read per slot), then for each fire runs a
// search pass, a slot read and the fire, plus a reload step for a periodic timer.
// Fire strobes are single cycle and never back to back; the receiver cannot stall.
// Reset clears all valid marks at once; the RAM needs no clearing pass.
`timescale 1ns / 1ps

module timer_event_scheduler import tes_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [KIND_W-1:0]      kind_i,
  input  logic [PORT_ID_W-1:0]   timer_id_i,
  input  logic [PORT_TIME_W-1:0] period_i,
  input  logic [PORT_TIME_W-1:0] start_time_i,
  input  logic [PORT_TIME_W-1:0] current_time_i,
  output logic                   fire_valid_o,
  output logic [PORT_ID_W-1:0]   fired_id_o,
  output logic [PORT_TIME_W-1:0] due_time_o,
  output logic                   last_fire_o
);

  state_e                state_q, state_d;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  logic                  pend_q, pend_d;
  slot_idx_t             idx_q, idx_d;
  logic [NUM_TIMERS-1:0] valid_q, valid_d;
  logic [NUM_TIMERS-1:0] due_q, due_d;
  logic                  found_q, found_d;
  logic                  last_q, last_d;
  logic                  fv_q, fv_d;
  slot_idx_t             best_q, best_d;

  time_t                 now_q, now_d;
  time_t                 best_dl_q, best_dl_d;
  time_t                 nd_q, nd_d;
  time_t                 per_q, per_d;
  logic [PORT_ID_W-1:0]  fid_q, fid_d;
  time_t                 fdue_q, fdue_d;
  logic                  flast_q, flast_d;

  // shared datapath
  time_t                 cmp_a, cmp_b;
  logic                  cmp_lt;
  time_t                 add_a, add_b;
  logic [TIME_BITS:0]    add_sum;
  time_t                 add_sat;

  logic                  ram_we, ram_re;
  slot_idx_t             ram_waddr, ram_raddr;
  slot_t                 ram_wdata, ram_rdata;

  logic                  rd_issue;
  logic                  id_ok;
  slot_idx_t             cmd_idx;
  time_t                 start_t, cur_t;
  logic [NUM_TIMERS-1:0] due_left;
  logic                  fire_last;

  assign cmp_lt  = cmp_a < cmp_b;
  assign add_sum = {1'b0, add_a} + {1'b0, add_b};
  assign add_sat = add_sum[TIME_BITS] ? '1 : add_sum[TIME_BITS-1:0];

  assign id_ok    = 32'(timer_id_i) < 32'(NUM_TIMERS);
  assign cmd_idx  = ID_BITS'(timer_id_i);
  assign start_t  = TIME_BITS'(start_time_i);
  assign cur_t    = TIME_BITS'(current_time_i);
  assign rd_issue = cnt_q < CNT_BITS'(NUM_TIMERS);

  always_comb begin
    due_left         = due_q;
    due_left[best_q] = 1'b0;
  end
  assign fire_last = (due_left == '0);

  tes_slot_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    pend_d    = 1'b0;
    idx_d     = idx_q;
    valid_d   = valid_q;
    due_d     = due_q;
    found_d   = found_q;
    last_d    = last_q;
    fv_d      = 1'b0;
    best_d    = best_q;
    now_d     = now_q;
    best_dl_d = best_dl_q;
    nd_d      = nd_q;
    per_d     = per_q;
    fid_d     = fid_q;
    fdue_d    = fdue_q;
    flast_d   = flast_q;

    cmp_a     = now_q;
    cmp_b     = ram_rdata.deadline;
    add_a     = now_q;
    add_b     = time_t'(1);

    ram_we    = 1'b0;
    ram_waddr = best_q;
    ram_wdata = '{deadline: nd_q, period: per_q};
    ram_re    = 1'b0;
    ram_raddr = cnt_q[ID_BITS-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          case (kind_i)
            KIND_ADD: begin
              if (id_ok) begin
                // deadline = max(start_time, now)
                cmp_a             = start_t;
                cmp_b             = cur_t;
                ram_we            = 1'b1;
                ram_waddr         = cmd_idx;
                ram_wdata         = '{deadline: cmp_lt ? cur_t : start_t,
                                      period:   TIME_BITS'(period_i)};
                valid_d[cmd_idx]  = 1'b1;
              end
            end
            KIND_REMOVE: begin
              if (id_ok) begin
                valid_d[cmd_idx] = 1'b0;
              end
            end
            KIND_TICK: begin
              now_d   = cur_t;
              cnt_d   = '0;
              due_d   = '0;
              state_d = S_SNAP;
            end
            default: ;
          endcase
        end
      end

      S_SNAP, S_FIND: begin
        ram_re = rd_issue;
        if (rd_issue) begin
          pend_d = 1'b1;
          idx_d  = cnt_q[ID_BITS-1:0];
          cnt_d  = cnt_q + CNT_BITS'(1);
        end
        if (pend_q) begin
          if (state_q == S_SNAP) begin
            // due when deadline <= now, i.e. !(now < deadline)
            cmp_a        = now_q;
            cmp_b        = ram_rdata.deadline;
            due_d[idx_q] = valid_q[idx_q] & ~cmp_lt;
          end else begin
            // strict compare keeps the lowest id on ties
            cmp_a = ram_rdata.deadline;
            cmp_b = best_dl_q;
            if (due_q[idx_q] && (!found_q || cmp_lt)) begin
              found_d   = 1'b1;
              best_d    = idx_q;
              best_dl_d = ram_rdata.deadline;
            end
          end
        end
        if (!rd_issue && !pend_q) begin
          if (state_q == S_SNAP) begin
            cnt_d   = '0;
            found_d = 1'b0;
            state_d = (due_q == '0) ? S_IDLE : S_FIND;
          end else begin
            state_d = S_RD;
          end
        end
      end

      S_RD: begin
        ram_re    = 1'b1;
        ram_raddr = best_q;
        state_d   = S_FIRE;
      end

      S_FIRE: begin
        fv_d          = 1'b1;
        fid_d         = PORT_ID_W'(best_q);
        fdue_d        = best_dl_q;
        flast_d       = fire_last;
        last_d        = fire_last;
        due_d[best_q] = 1'b0;
        cnt_d         = '0;
        found_d       = 1'b0;
        if (ram_rdata.period != '0) begin
          add_a   = best_dl_q;
          add_b   = ram_rdata.period;
          nd_d    = add_sat;
          per_d   = ram_rdata.period;
          state_d = S_RELOAD;
        end else begin
          valid_d[best_q] = 1'b0;
          state_d         = fire_last ? S_IDLE : S_FIND;
        end
      end

      S_RELOAD: begin
        // keep deadline+period if still in the future, else now+1
        cmp_a     = now_q;
        cmp_b     = nd_q;
        add_a     = now_q;
        add_b     = time_t'(1);
        ram_we    = 1'b1;
        ram_waddr = best_q;
        ram_wdata = '{deadline: cmp_lt ? nd_q : add_sat, period: per_q};
        cnt_d     = '0;
        found_d   = 1'b0;
        state_d   = last_q ? S_IDLE : S_FIND;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      idx_q   <= '0;
      valid_q <= '0;
      due_q   <= '0;
      found_q <= 1'b0;
      last_q  <= 1'b0;
      fv_q    <= 1'b0;
      best_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      idx_q   <= idx_d;
      valid_q <= valid_d;
      due_q   <= due_d;
      found_q <= found_d;
      last_q  <= last_d;
      fv_q    <= fv_d;
      best_q  <= best_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q     <= now_d;
    best_dl_q <= best_dl_d;
    nd_q      <= nd_d;
    per_q     <= per_d;
    fid_q     <= fid_d;
    fdue_q    <= fdue_d;
    flast_q   <= flast_d;
  end

  assign busy         = (state_q != S_IDLE);
  assign fire_valid_o = fv_q;
  assign fired_id_o   = fid_q;
  assign due_time_o   = PORT_TIME_W'(fdue_q);
  assign last_fire_o  = flast_q;

endmodule

>>> sv/tes_checker.sv
// tes_sva: port-level assertions for timer_event_scheduler, attached by bind.
// Depends on tes_pkg.
`timescale 1ns / 1ps

module tes_sva import tes_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic [KIND_W-1:0] kind_i,
  input logic              fire_valid_o,
  input logic              last_fire_o
);

  // add, remove and unused kinds finish in the accept cycle
  a_cmd_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && kind_i != KIND_TICK) |=> !busy)
    else $error("add/remove transaction left the block busy");

  // more fires follow a non-final fire, so the block stays busy
  a_not_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_valid_o && !last_fire_o) |=> busy)
    else $error("block went idle after a non-final fire");

  // each fire needs a full search pass, strobes never come back to back
  a_no_b2b_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_valid_o |=> !fire_valid_o)
    else $error("fire strobes in consecutive cycles");

endmodule

bind timer_event_scheduler tes_sva u_tes_sva (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .kind_i       (kind_i),
  .fire_valid_o (fire_valid_o),
  .last_fire_o  (last_fire_o)
);

>>> sim/tes_checker.sv
// tes_checker: watches the command and fire channels of timer_event_scheduler,
// keeps its own copy of the timer table and compares every fire. Depends on tes_pkg.
`timescale 1ns / 1ps

module tes_checker import tes_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   busy_i,
  input  logic [KIND_W-1:0]      kind_i,
  input  logic [PORT_ID_W-1:0]   timer_id_i,
  input  logic [PORT_TIME_W-1:0] period_i,
  input  logic [PORT_TIME_W-1:0] start_time_i,
  input  logic [PORT_TIME_W-1:0] current_time_i,
  input  logic                   fire_valid_i,
  input  logic [PORT_ID_W-1:0]   fired_id_i,
  input  logic [PORT_TIME_W-1:0] due_time_i,
  input  logic                   last_fire_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  typedef struct packed {
    logic [PORT_ID_W-1:0]   id;
    logic [PORT_TIME_W-1:0] due;
    logic                   last;
  } fire_t;

  logic  armed_q    [NUM_TIMERS];
  time_t deadline_q [NUM_TIMERS];
  time_t period_q   [NUM_TIMERS];
  fire_t pending_fires_q [$];
  fire_t head_fire;

  function automatic time_t add_sat(time_t a, time_t b);
    logic [TIME_BITS:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
  endfunction

  // Due set is frozen at tick start, so each timer fires at most once per tick.
  task automatic predict_tick(input time_t now_ms);
    logic  due [NUM_TIMERS];
    int    num_due;
    int    best;
    time_t reload;
    fire_t f;
    num_due = 0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      due[i] = armed_q[i] && (deadline_q[i] <= now_ms);
      if (due[i]) num_due++;
    end
    for (int k = 0; k < num_due; k++) begin
      best = -1;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        if (due[i] && (best < 0 || deadline_q[i] < deadline_q[best])) best = i;
      end
      due[best] = 1'b0;
      f.id   = PORT_ID_W'(best);
      f.due  = PORT_TIME_W'(deadline_q[best]);
      f.last = (k == num_due - 1);
      pending_fires_q = {pending_fires_q, f};
      if (period_q[best] != '0) begin
        reload = add_sat(deadline_q[best], period_q[best]);
        if (reload <= now_ms) reload = add_sat(now_ms, time_t'(1));
        deadline_q[best] = reload;
      end else begin
        armed_q[best]    = 1'b0;
        deadline_q[best] = '0;
      end
    end
  endtask

  task automatic apply_command();
    int    slot;
    time_t now_ms;
    time_t first_due;
    slot      = int'(timer_id_i);
    now_ms    = time_t'(current_time_i);
    first_due = time_t'(start_time_i);
    case (kind_i)
      KIND_ADD: begin
        if (slot < NUM_TIMERS) begin
          armed_q[slot]    = 1'b1;
          deadline_q[slot] = (first_due < now_ms) ? now_ms : first_due;
          period_q[slot]   = time_t'(period_i);
        end
      end
      KIND_REMOVE: begin
        if (slot < NUM_TIMERS) begin
          armed_q[slot]    = 1'b0;
          deadline_q[slot] = '0;
          period_q[slot]   = '0;
        end
      end
      KIND_TICK: begin
        predict_tick(now_ms);
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        armed_q[i]    = 1'b0;
        deadline_q[i] = '0;
        period_q[i]   = '0;
      end
      pending_fires_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // fires seen at this edge belong to transactions accepted earlier
      if (fire_valid_i) begin
        if (pending_fires_q.size() == 0) begin
          $display("%0t: unexpected fire: expected none, actual id %0d due %0d last %0b",
                   $time, fired_id_i, due_time_i, last_fire_i);
          fail_count_o++;
        end else begin
          head_fire = pending_fires_q.pop_front();
          if (fired_id_i !== head_fire.id) begin
            $display("%0t: fired_id mismatch: expected %0d, actual %0d",
                     $time, head_fire.id, fired_id_i);
            fail_count_o++;
          end
          if (due_time_i !== head_fire.due) begin
            $display("%0t: due_time mismatch: expected %0d, actual %0d",
                     $time, head_fire.due, due_time_i);
            fail_count_o++;
          end
          if (last_fire_i !== head_fire.last) begin
            $display("%0t: last_fire mismatch: expected %0b, actual %0b",
                     $time, head_fire.last, last_fire_i);
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_i) apply_command();
      pending_o = pending_fires_q.size();
    end
  end

endmodule

>>> sim/tb_timer_event_scheduler.sv
// tb_timer_event_scheduler: drives add, remove and tick commands into
// timer_event_scheduler and gives the verdict. Depends on tes_pkg, tes_checker.
`timescale 1ns / 1ps

module tb_timer_event_scheduler;
  import tes_pkg::*;

  localparam int MAX_CYCLES   = 1_000_000;
  localparam int RANDOM_ITEMS = 360;
  localparam int MAX_GAP      = 8;
  localparam int DRAIN_CYCLES = 4 * NUM_TIMERS + 40;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start;
  logic                   busy;
  logic [KIND_W-1:0]      kind;
  logic [PORT_ID_W-1:0]   timer_id;
  logic [PORT_TIME_W-1:0] period;
  logic [PORT_TIME_W-1:0] start_time;
  logic [PORT_TIME_W-1:0] current_time;
  logic                   fire_valid;
  logic [PORT_ID_W-1:0]   fired_id;
  logic [PORT_TIME_W-1:0] due_time;
  logic                   last_fire;
  int                     fail_count;
  int                     pending;
  int                     cycle_count;
  int                     no_gap_left;
  logic [PORT_TIME_W-1:0] now_ms;

  timer_event_scheduler uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind),
    .timer_id_i     (timer_id),
    .period_i       (period),
    .start_time_i   (start_time),
    .current_time_i (current_time),
    .fire_valid_o   (fire_valid),
    .fired_id_o     (fired_id),
    .due_time_o     (due_time),
    .last_fire_o    (last_fire)
  );

  tes_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .kind_i         (kind),
    .timer_id_i     (timer_id),
    .period_i       (period),
    .start_time_i   (start_time),
    .current_time_i (current_time),
    .fire_valid_i   (fire_valid),
    .fired_id_i     (fired_id),
    .due_time_i     (due_time),
    .last_fire_i    (last_fire),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= MAX_CYCLES) begin
      $display("FAIL timer_event_scheduler");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with start still high, so a back-to-back transaction keeps it up.
  task automatic send_cmd(input logic [KIND_W-1:0] k, input logic [PORT_ID_W-1:0] id,
                          input logic [PORT_TIME_W-1:0] per,
                          input logic [PORT_TIME_W-1:0] first_due,
                          input logic [PORT_TIME_W-1:0] at_ms);
    int gap;
    if (no_gap_left > 0) begin
      gap = 0;
      no_gap_left--;
    end else begin
      gap = $urandom_range(0, MAX_GAP);
      if ($urandom_range(0, 29) == 0) no_gap_left = $urandom_range(10, 30);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    kind         <= k;
    timer_id     <= id;
    period       <= per;
    start_time   <= first_due;
    current_time <= at_ms;
    start        <= 1'b1;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic logic [PORT_TIME_W-1:0] pick_period();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return '0;
    if (r < 8) return PORT_TIME_W'($urandom_range(1, 30));
    if (r == 8) return PORT_TIME_W'($urandom);
    return '1 - PORT_TIME_W'($urandom_range(0, 3));
  endfunction

  function automatic logic [PORT_TIME_W-1:0] pick_start(input logic [PORT_TIME_W-1:0] at_ms);
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return at_ms + PORT_TIME_W'($urandom_range(0, 40));
    if (r == 7) return at_ms - PORT_TIME_W'($urandom_range(0, 40));
    if (r == 8) return PORT_TIME_W'($urandom);
    return '1;
  endfunction

  initial begin
    int                     sent;
    int                     r;
    logic [PORT_TIME_W-1:0] common_due;
    logic                   paused_mid;
    rst_ni       = 1'b0;
    start        = 1'b0;
    kind         = KIND_ADD;
    timer_id     = '0;
    period       = '0;
    start_time   = '0;
    current_time = '0;
    cycle_count  = 0;
    no_gap_left  = 0;
    now_ms       = '0;
    sent         = 0;
    paused_mid   = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty tick, unused kind, idle remove, ties, clamp, saturation
    send_cmd(KIND_TICK,   4'd0,  '0, '0, 32'd0);
    send_cmd(KIND_NONE,   4'd5,  '1, '1, '1);
    send_cmd(KIND_REMOVE, 4'd5,  '0, '0, '0);
    send_cmd(KIND_ADD,    4'd0,  32'd0, 32'd100, 32'd50);
    send_cmd(KIND_ADD,    4'd15, '1, 32'd0, 32'd200);
    send_cmd(KIND_ADD,    4'd7,  32'd10, 32'd100, 32'd0);
    send_cmd(KIND_ADD,    4'd3,  32'd5, 32'd100, 32'd0);
    send_cmd(KIND_TICK,   4'd0,  '0, '0, 32'd99);
    send_cmd(KIND_TICK,   4'd0,  '0, '0, 32'd100);
    send_cmd(KIND_TICK,   4'd0,  '0, '0, 32'd1000);
    send_cmd(KIND_ADD,    4'd9,  32'd1, '1, '1);
    send_cmd(KIND_TICK,   4'd0,  '0, '0, '1);
    // reloads saturate and stay due; they must not fire twice in one tick
    send_cmd(KIND_TICK,   4'd0,  '0, '0, '1);
    send_cmd(KIND_ADD,    4'd9,  32'd0, 32'd40, 32'd20);
    send_cmd(KIND_REMOVE, 4'd15, '0, '0, '0);
    send_cmd(KIND_REMOVE, 4'd3,  '0, '0, '0);
    send_cmd(KIND_TICK,   4'd0,  '0, '0, 32'd50);
    send_cmd(KIND_ADD,    4'd4,  32'd0, 32'd0, 32'd0);
    send_cmd(KIND_TICK,   4'd0,  '0, '0, 32'd0);
    wait_drained();

    while (sent < RANDOM_ITEMS) begin
      if (!paused_mid && sent >= RANDOM_ITEMS / 2) begin
        wait_drained();
        paused_mid = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
        // arm every slot on one deadline, then tick: maximal fire burst
        common_due = now_ms + PORT_TIME_W'($urandom_range(0, 5));
        for (int s = 0; s < NUM_TIMERS; s++) begin
          send_cmd(KIND_ADD, PORT_ID_W'(s),
                   ($urandom_range(0, 1) != 0) ? '0 : PORT_TIME_W'($urandom_range(1, 8)),
                   common_due, now_ms);
        end
        now_ms = common_due;
        send_cmd(KIND_TICK, PORT_ID_W'($urandom), '0, '0, now_ms);
        sent += NUM_TIMERS + 1;
      end else if (r < 38) begin
        send_cmd(KIND_ADD, PORT_ID_W'($urandom), pick_period(), pick_start(now_ms), now_ms);
        sent++;
      end else if (r < 50) begin
        send_cmd(KIND_REMOVE, PORT_ID_W'($urandom), PORT_TIME_W'($urandom),
                 PORT_TIME_W'($urandom), now_ms);
        sent++;
      end else if (r < 54) begin
        // unused kind: ignored, not counted
        send_cmd(KIND_NONE, PORT_ID_W'($urandom), PORT_TIME_W'($urandom),
                 PORT_TIME_W'($urandom), PORT_TIME_W'($urandom));
      end else if (r < 58) begin
        // noise: any command with unrelated times, clock may run backwards
        send_cmd(KIND_W'($urandom_range(0, 2)), PORT_ID_W'($urandom), PORT_TIME_W'($urandom),
                 PORT_TIME_W'($urandom), PORT_TIME_W'($urandom));
        sent++;
      end else if (r < 61) begin
        now_ms = ($urandom_range(0, 1) != 0) ? PORT_TIME_W'($urandom)
                                             : '1 - PORT_TIME_W'($urandom_range(0, 60));
        send_cmd(KIND_TICK, PORT_ID_W'($urandom), '0, '0, now_ms);
        sent++;
      end else begin
        now_ms = now_ms + PORT_TIME_W'($urandom_range(0, 25));
        send_cmd(KIND_TICK, PORT_ID_W'($urandom), PORT_TIME_W'($urandom),
                 PORT_TIME_W'($urandom), now_ms);
        sent++;
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS timer_event_scheduler");
    end else begin
      $display("FAIL timer_event_scheduler");
    end
    $finish;
  end

endmodule
